// ===== hdl/ltms_pkg.sv =====
// Shared types, constants and helper functions for the local truncated-mean smoother.
// Used by ltms_ctrl, ltms_datapath and local_truncated_mean_smoother; no dependencies.
package ltms_pkg;

  // Field widths
  localparam int unsigned R_W   = 16;
  localparam int unsigned Q_W   = 20;
  localparam int unsigned RAD_W = 12;

  // Window geometry
  localparam int unsigned MAX_HALF_WINDOW = 31;
  localparam int unsigned HW_W        = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned RING_DEPTH  = 2 * (MAX_HALF_WINDOW + 1);
  localparam int unsigned RING_AW     = $clog2(RING_DEPTH);
  localparam int unsigned RING_W      = R_W + Q_W;
  localparam int unsigned MAX_RESULTS = MAX_HALF_WINDOW + 1;
  localparam int unsigned NOUT_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CNT_W       = 16;

  // Arithmetic widths (set size is below RING_DEPTH)
  localparam int unsigned N_W    = RING_AW;
  localparam int unsigned SUM_W  = Q_W + N_W;
  localparam int unsigned SQ_W   = 2 * Q_W;
  localparam int unsigned SSQ_W  = SQ_W + N_W;
  localparam int unsigned VAR_W  = 2 * SUM_W;
  localparam int unsigned NN_W   = 2 * N_W;
  localparam int unsigned BIT_W  = $clog2(Q_W);
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned SEQ_W  = $clog2(DIV_STEPS);
  localparam int unsigned DRAIN_LAST = 2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(16);

  typedef struct packed {
    logic [R_W-1:0] residual_range;
    logic [Q_W-1:0] charge;
    logic           last_point;
  } ltms_in_t;

  typedef struct packed {
    logic [Q_W-1:0] smoothed_charge;
    logic           last_result;
  } ltms_out_t;

  typedef enum logic [1:0] {
    PASS_SUMS,
    PASS_RADIX,
    PASS_BAND
  } ltms_pass_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RC,
    ST_SCAN,
    ST_DRAIN,
    ST_VAR0,
    ST_VAR1,
    ST_RSTEP,
    ST_DIVINIT,
    ST_DIV,
    ST_EMIT
  } ltms_state_e;

  typedef struct packed {
    logic               ring_wr;
    logic [RING_AW-1:0] wr_addr;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic               scan;
    ltms_pass_e         pass;
    logic               rc_load;
    logic               var0;
    logic               var1;
    logic [BIT_W-1:0]   bit_idx;
    logic               radix_step;
    logic               div_init;
    logic               div_step;
    logic               out_load;
    logic               out_last;
    logic               use_median;
  } ltms_cmd_t;

  typedef struct packed {
    logic band_empty;
  } ltms_stat_t;

  // Half window: floor(radius*3/8), saturated
  function automatic logic [HW_W-1:0] half_window(input logic [RAD_W-1:0] radius);
    logic [RAD_W+1:0] t;
    logic [RAD_W+1:0] h;
    t = {2'b00, radius} + {1'b0, radius, 1'b0};
    h = t >> 3;
    if (h > (RAD_W+2)'(MAX_HALF_WINDOW)) begin
      return HW_W'(MAX_HALF_WINDOW);
    end
    return h[HW_W-1:0];
  endfunction

endpackage

// ===== hdl/ltms_ctrl.sv =====
// Sequencer for the smoother: item intake, centre bookkeeping and per-centre pass control.
// Depends on ltms_pkg; drives ltms_datapath through an ltms_cmd_t command struct.
module ltms_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [ltms_pkg::RAD_W-1:0]    radius_i,
  input  ltms_pkg::ltms_stat_t          stat_i,
  output ltms_pkg::ltms_cmd_t           cmd_o
);

  ltms_pkg::ltms_state_e state_q, state_d;
  ltms_pkg::ltms_pass_e  pass_q, pass_d;
  logic [ltms_pkg::CNT_W-1:0]   pr_q, pr_d;
  logic [ltms_pkg::CNT_W-1:0]   nc_q, nc_d;
  logic                         last_q, last_d;
  logic [ltms_pkg::NOUT_W-1:0]  nout_q, nout_d;
  logic [ltms_pkg::RING_AW-1:0] k_q, k_d;
  logic [ltms_pkg::RING_AW-1:0] span_q, span_d;
  logic [ltms_pkg::RING_AW-1:0] base_q, base_d;
  logic [ltms_pkg::BIT_W-1:0]   bit_q, bit_d;
  logic [ltms_pkg::SEQ_W-1:0]   cnt_q, cnt_d;
  logic                         res_last_q, res_last_d;
  logic                         out_valid_q, out_valid_d;

  logic [ltms_pkg::HW_W-1:0]  h;
  logic [ltms_pkg::CNT_W-1:0] pending;
  logic [ltms_pkg::CNT_W-1:0] above;
  logic [ltms_pkg::HW_W-1:0]  up;
  logic [ltms_pkg::HW_W-1:0]  dn;
  logic                       stop;

  // Window geometry of the next centre
  always_comb begin
    h       = ltms_pkg::half_window(radius_i);
    pending = pr_q - nc_q;
    above   = pr_q - ltms_pkg::CNT_W'(1) - nc_q;
    up      = (above < ltms_pkg::CNT_W'(h)) ? above[ltms_pkg::HW_W-1:0] : h;
    dn      = (nc_q < ltms_pkg::CNT_W'(h)) ? nc_q[ltms_pkg::HW_W-1:0] : h;
    stop    = (last_q ? (pending == '0) : (pending <= ltms_pkg::CNT_W'(h))) ||
              (nout_q == ltms_pkg::NOUT_W'(ltms_pkg::MAX_RESULTS));
  end

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ltms_pkg::ST_IDLE;
      pass_q      <= ltms_pkg::PASS_SUMS;
      pr_q        <= '0;
      nc_q        <= '0;
      last_q      <= 1'b0;
      nout_q      <= '0;
      k_q         <= '0;
      span_q      <= '0;
      base_q      <= '0;
      bit_q       <= '0;
      cnt_q       <= '0;
      res_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      pr_q        <= pr_d;
      nc_q        <= nc_d;
      last_q      <= last_d;
      nout_q      <= nout_d;
      k_q         <= k_d;
      span_q      <= span_d;
      base_q      <= base_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      res_last_q  <= res_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    pr_d       = pr_q;
    nc_d       = nc_q;
    last_d     = last_q;
    nout_d     = nout_q;
    k_d        = k_q;
    span_d     = span_q;
    base_d     = base_q;
    bit_d      = bit_q;
    cnt_d      = cnt_q;
    res_last_d = res_last_q;
    in_ready_o = 1'b0;

    cmd_o            = '0;
    cmd_o.pass       = pass_q;
    cmd_o.bit_idx    = bit_q;
    cmd_o.wr_addr    = pr_q[ltms_pkg::RING_AW-1:0];
    cmd_o.rd_addr    = base_q + k_q;
    cmd_o.out_last   = res_last_q;
    cmd_o.use_median = stat_i.band_empty;

    case (state_q)
      ltms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ring_wr = 1'b1;
          pr_d    = pr_q + ltms_pkg::CNT_W'(1);
          last_d  = in_last_i;
          nout_d  = '0;
          state_d = ltms_pkg::ST_CHECK;
        end
      end
      ltms_pkg::ST_CHECK: begin
        if (stop) begin
          if (last_q) begin
            pr_d = '0;
            nc_d = '0;
          end
          state_d = ltms_pkg::ST_IDLE;
        end else begin
          // fetch the centre's range, latch window bounds
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = nc_q[ltms_pkg::RING_AW-1:0];
          span_d = ltms_pkg::RING_AW'(dn) + ltms_pkg::RING_AW'(up) +
                   ltms_pkg::RING_AW'(1);
          base_d = nc_q[ltms_pkg::RING_AW-1:0] - ltms_pkg::RING_AW'(dn);
          res_last_d = last_q && (pending == ltms_pkg::CNT_W'(1));
          state_d = ltms_pkg::ST_RC;
        end
      end
      ltms_pkg::ST_RC: begin
        cmd_o.rc_load = 1'b1;
        pass_d  = ltms_pkg::PASS_SUMS;
        k_d     = '0;
        state_d = ltms_pkg::ST_SCAN;
      end
      ltms_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.scan  = 1'b1;
        if (k_q == span_q - ltms_pkg::RING_AW'(1)) begin
          cnt_d   = '0;
          state_d = ltms_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + ltms_pkg::RING_AW'(1);
        end
      end
      ltms_pkg::ST_DRAIN: begin
        // let the last reads pass the three datapath stages
        if (cnt_q == ltms_pkg::SEQ_W'(ltms_pkg::DRAIN_LAST)) begin
          case (pass_q)
            ltms_pkg::PASS_SUMS:  state_d = ltms_pkg::ST_VAR0;
            ltms_pkg::PASS_RADIX: state_d = ltms_pkg::ST_RSTEP;
            default:              state_d = ltms_pkg::ST_DIVINIT;
          endcase
        end else begin
          cnt_d = cnt_q + ltms_pkg::SEQ_W'(1);
        end
      end
      ltms_pkg::ST_VAR0: begin
        cmd_o.var0 = 1'b1;
        state_d = ltms_pkg::ST_VAR1;
      end
      ltms_pkg::ST_VAR1: begin
        cmd_o.var1 = 1'b1;
        pass_d  = ltms_pkg::PASS_RADIX;
        bit_d   = ltms_pkg::BIT_W'(ltms_pkg::Q_W - 1);
        k_d     = '0;
        state_d = ltms_pkg::ST_SCAN;
      end
      ltms_pkg::ST_RSTEP: begin
        cmd_o.radix_step = 1'b1;
        k_d     = '0;
        state_d = ltms_pkg::ST_SCAN;
        if (bit_q == '0) begin
          pass_d = ltms_pkg::PASS_BAND;
        end else begin
          bit_d = bit_q - ltms_pkg::BIT_W'(1);
        end
      end
      ltms_pkg::ST_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = ltms_pkg::ST_DIV;
      end
      ltms_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == ltms_pkg::SEQ_W'(ltms_pkg::DIV_STEPS - 1)) begin
          state_d = ltms_pkg::ST_EMIT;
        end else begin
          cnt_d = cnt_q + ltms_pkg::SEQ_W'(1);
        end
      end
      ltms_pkg::ST_EMIT: begin
        // load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          nc_d    = nc_q + ltms_pkg::CNT_W'(1);
          nout_d  = nout_q + ltms_pkg::NOUT_W'(1);
          state_d = ltms_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = ltms_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ltms_datapath.sv =====
// Datapath of the smoother: point ring, scan pipeline, moments, radix median,
// band test, serial divider and output register. Depends on ltms_pkg.
module ltms_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ltms_pkg::ltms_in_t         in_data_i,
  input  logic [ltms_pkg::RAD_W-1:0] radius_i,
  input  ltms_pkg::ltms_cmd_t        cmd_i,
  output ltms_pkg::ltms_stat_t       stat_o,
  output ltms_pkg::ltms_out_t        out_data_o
);

  logic [ltms_pkg::RING_W-1:0] ring_mem [ltms_pkg::RING_DEPTH];
  logic [ltms_pkg::RING_W-1:0] rd_q;

  logic [ltms_pkg::R_W-1:0]   rc_q;
  logic [ltms_pkg::R_W-1:0]   rd_r;
  logic [ltms_pkg::Q_W-1:0]   rd_c;
  logic [ltms_pkg::R_W-1:0]   dr;
  logic                       in_a;
  logic [ltms_pkg::Q_W-1:0]   diff;
  logic [ltms_pkg::Q_W-1:0]   mop;
  logic [ltms_pkg::Q_W-1:0]   hi_mask;
  logic                       radix_hit;

  logic                       va_q, vb_q, vc_q;
  logic                       inb_q, inc_q;
  logic [ltms_pkg::Q_W-1:0]   qb_q, qc_q;
  logic [ltms_pkg::SQ_W-1:0]  mb_q;
  logic [ltms_pkg::VAR_W-1:0] pc_q;

  logic [ltms_pkg::N_W-1:0]   n_q;
  logic [ltms_pkg::SUM_W-1:0] sum_q;
  logic [ltms_pkg::SSQ_W-1:0] sumsq_q;
  logic [ltms_pkg::VAR_W-1:0] p1_q, p2_q, var_q;
  logic [ltms_pkg::NN_W-1:0]  nn1_q;
  logic [ltms_pkg::Q_W-1:0]   prefix_q;
  logic [ltms_pkg::N_W-1:0]   kr_q, c0_q;
  logic [ltms_pkg::SUM_W-1:0] band_sum_q;
  logic [ltms_pkg::N_W-1:0]   band_n_q;
  logic [ltms_pkg::SUM_W-1:0] dvd_q;
  logic [ltms_pkg::N_W-1:0]   rem_q;
  logic [ltms_pkg::N_W:0]     trial;
  logic [ltms_pkg::N_W:0]     rem_nx;
  logic                       ge;
  ltms_pkg::ltms_out_t        out_q;

  // Point ring: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_wr) begin
      ring_mem[cmd_i.wr_addr] <= {in_data_i.residual_range, in_data_i.charge};
    end
    if (cmd_i.rd_en) begin
      rd_q <= ring_mem[cmd_i.rd_addr];
    end
  end

  // Stage A: set membership, radix match, operand for the square
  always_comb begin
    rd_r      = rd_q[ltms_pkg::RING_W-1:ltms_pkg::Q_W];
    rd_c      = rd_q[ltms_pkg::Q_W-1:0];
    dr        = (rd_r > rc_q) ? (rd_r - rc_q) : (rc_q - rd_r);
    in_a      = dr <= ltms_pkg::R_W'(radius_i);
    diff      = (rd_c > prefix_q) ? (rd_c - prefix_q) : (prefix_q - rd_c);
    mop       = (cmd_i.pass == ltms_pkg::PASS_BAND) ? diff : rd_c;
    hi_mask   = {ltms_pkg::Q_W{1'b1}} << (cmd_i.bit_idx + ltms_pkg::BIT_W'(1));
    radix_hit = (((rd_c ^ prefix_q) & hi_mask) == '0) && !rd_c[cmd_i.bit_idx];
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= cmd_i.rd_en && cmd_i.scan;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stages B and C: square, then scale by n*(n-1)
  always_ff @(posedge clk_i) begin
    qb_q  <= rd_c;
    inb_q <= in_a;
    mb_q  <= ltms_pkg::SQ_W'(mop) * ltms_pkg::SQ_W'(mop);
    qc_q  <= qb_q;
    inc_q <= inb_q;
    pc_q  <= ltms_pkg::VAR_W'(mb_q) * ltms_pkg::VAR_W'(nn1_q);
  end

  // Centre range and set moments
  always_ff @(posedge clk_i) begin
    if (cmd_i.rc_load) begin
      rc_q       <= rd_q[ltms_pkg::RING_W-1:ltms_pkg::Q_W];
      n_q        <= '0;
      sum_q      <= '0;
      sumsq_q    <= '0;
      band_sum_q <= '0;
      band_n_q   <= '0;
    end else begin
      if (vb_q && inb_q && cmd_i.pass == ltms_pkg::PASS_SUMS) begin
        n_q     <= n_q + ltms_pkg::N_W'(1);
        sum_q   <= sum_q + ltms_pkg::SUM_W'(qb_q);
        sumsq_q <= sumsq_q + ltms_pkg::SSQ_W'(mb_q);
      end
      // accumulate charges strictly inside the band
      if (vc_q && inc_q && cmd_i.pass == ltms_pkg::PASS_BAND &&
          n_q > ltms_pkg::N_W'(1) && pc_q < var_q) begin
        band_sum_q <= band_sum_q + ltms_pkg::SUM_W'(qc_q);
        band_n_q   <= band_n_q + ltms_pkg::N_W'(1);
      end
    end
  end

  // Sample variance scaled by n*(n-1), and n*(n-1) itself
  always_ff @(posedge clk_i) begin
    if (cmd_i.var0) begin
      p1_q  <= ltms_pkg::VAR_W'(n_q) * ltms_pkg::VAR_W'(sumsq_q);
      p2_q  <= ltms_pkg::VAR_W'(sum_q) * ltms_pkg::VAR_W'(sum_q);
      nn1_q <= ltms_pkg::NN_W'(n_q) * ltms_pkg::NN_W'(n_q - ltms_pkg::N_W'(1));
    end
    if (cmd_i.var1) begin
      var_q <= p1_q - p2_q;
    end
  end

  // Radix selection of the upper median, one bit per pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.var0) begin
      prefix_q <= '0;
      kr_q     <= n_q >> 1;
      c0_q     <= '0;
    end else if (cmd_i.radix_step) begin
      if (kr_q >= c0_q) begin
        prefix_q[cmd_i.bit_idx] <= 1'b1;
        kr_q <= kr_q - c0_q;
      end
      c0_q <= '0;
    end else if (va_q && in_a && radix_hit && cmd_i.pass == ltms_pkg::PASS_RADIX) begin
      c0_q <= c0_q + ltms_pkg::N_W'(1);
    end
  end

  // Restoring divider: band sum by band count
  always_comb begin
    trial  = {rem_q, dvd_q[ltms_pkg::SUM_W-1]};
    ge     = trial >= {1'b0, band_n_q};
    rem_nx = ge ? (trial - {1'b0, band_n_q}) : trial;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= band_sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[ltms_pkg::SUM_W-2:0], ge};
      rem_q <= rem_nx[ltms_pkg::N_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.smoothed_charge <= cmd_i.use_median ? prefix_q : dvd_q[ltms_pkg::Q_W-1:0];
      out_q.last_result     <= cmd_i.out_last;
    end
  end

  assign stat_o.band_empty = (band_n_q == '0);
  assign out_data_o        = out_q;

endmodule

// ===== hdl/local_truncated_mean_smoother.sv =====
// One result per centre; it may wait at the output. For W = window points (1..63),
// each centre takes one sums pass, twenty radix-median passes and one band pass over
// the single ring read port, then a 26-step divider. Items are taken one at a time; an
// item that releases no result returns to ready via the check state. Reset (rst_ni low,
// asynchronous) clears counters, FSM and valids and sets radius to 16; the ring has no reset.
// Top level: radius register, controller and datapath. Depends on ltms_pkg, ltms_ctrl,
// ltms_datapath.
module local_truncated_mean_smoother (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ltms_pkg::ltms_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ltms_pkg::ltms_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ltms_pkg::RAD_W-1:0] cfg_data_i
);

  logic [ltms_pkg::RAD_W-1:0] radius_q;
  ltms_pkg::ltms_cmd_t        cmd;
  ltms_pkg::ltms_stat_t       stat;

  // Radius register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= ltms_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  ltms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_point),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .radius_i    (radius_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ltms_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .radius_i   (radius_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // Never overwrite an item waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // One item in flight: no intake right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted back to back");

  // Ring scans only happen while busy
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !in_ready_o)
    else $error("ring scan while idle");

endmodule
